FILE: src/sfi_pkg.sv
// Package with the word types and control struct of the simplest-fraction block.
`timescale 1ns / 1ps

package sfi_pkg;

    // Width of the input fields and of the result fields.
    localparam int IN_W  = 16;
    localparam int OUT_W = 18;

    typedef struct packed {
        logic [IN_W-1:0] low_num;
        logic [IN_W-1:0] high_num;
        logic [IN_W-1:0] common_den;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] frac_num;
        logic [OUT_W-1:0] frac_den;
        logic             bad_interval;
    } t_out_word;

    // Commands from the sequencer to the mediant unit.
    typedef struct packed {
        logic load;
        logic step;
    } t_sfi_ctl;

endpackage

FILE: src/sfi_bounds.sv
// Working bounds of the Stern-Brocot descent and the shared mediant step unit.
`timescale 1ns / 1ps

module sfi_bounds #(
    parameter int DEN_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfi_pkg::t_sfi_ctl     i_ctl,
    input  logic [DEN_BITS-1:0]   i_lo,
    input  logic [DEN_BITS-1:0]   i_hi,
    input  logic [DEN_BITS-1:0]   i_dn,
    output logic                  o_hit,
    output logic [DEN_BITS+1:0]   o_med_num,
    output logic [DEN_BITS+1:0]   o_med_den
);

    localparam int FW = DEN_BITS + 2;
    localparam int SW = 2 * DEN_BITS + 4;

    // Bound terms p/q carry two scores: p*dn - lo*q and p*dn - hi*q.
    // They are linear, so the scores of a mediant are sums of the bound scores.
    logic [FW-1:0]        r_a, r_b, r_c, r_d;
    logic [FW-1:0]        n_a, n_b, n_c, n_d;
    logic signed [SW-1:0] r_sl_lo, r_sl_hi, r_sr_lo, r_sr_hi;
    logic signed [SW-1:0] n_sl_lo, n_sl_hi, n_sr_lo, n_sr_hi;

    logic signed [SW-1:0] w_lo_s, w_hi_s, w_dn_s;
    logic signed [SW-1:0] w_m_lo, w_m_hi;
    logic [FW-1:0]        w_mn, w_md;
    logic                 w_above_lo, w_below_hi;

    assign w_lo_s = SW'(i_lo);
    assign w_hi_s = SW'(i_hi);
    assign w_dn_s = SW'(i_dn);

    assign w_mn   = r_a + r_c;
    assign w_md   = r_b + r_d;
    assign w_m_lo = r_sl_lo + r_sr_lo;
    assign w_m_hi = r_sl_hi + r_sr_hi;

    assign w_above_lo = (w_m_lo > 0);
    assign w_below_hi = (w_m_hi < 0);

    assign o_hit     = w_above_lo && w_below_hi;
    assign o_med_num = w_mn;
    assign o_med_den = w_md;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_sl_lo = r_sl_lo;
        n_sl_hi = r_sl_hi;
        n_sr_lo = r_sr_lo;
        n_sr_hi = r_sr_hi;
        priority if (i_ctl.load) begin
            // Start from the bounds 0/1 and 1/1.
            n_a     = FW'(0);
            n_b     = FW'(1);
            n_c     = FW'(1);
            n_d     = FW'(1);
            n_sl_lo = -w_lo_s;
            n_sl_hi = -w_hi_s;
            n_sr_lo = w_dn_s - w_lo_s;
            n_sr_hi = w_dn_s - w_hi_s;
        end else if (i_ctl.step) begin
            if (w_above_lo) begin
                // Mediant at or above the upper bound: it becomes the right bound.
                n_c     = w_mn;
                n_d     = w_md;
                n_sr_lo = w_m_lo;
                n_sr_hi = w_m_hi;
            end else begin
                n_a     = w_mn;
                n_b     = w_md;
                n_sl_lo = w_m_lo;
                n_sl_hi = w_m_hi;
            end
        end else begin
            n_a = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= FW'(0);
            r_b     <= FW'(1);
            r_c     <= FW'(1);
            r_d     <= FW'(1);
            r_sl_lo <= '0;
            r_sl_hi <= '0;
            r_sr_lo <= '0;
            r_sr_hi <= '0;
        end else begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_sl_lo <= n_sl_lo;
            r_sl_hi <= n_sl_hi;
            r_sr_lo <= n_sr_lo;
            r_sr_hi <= n_sr_hi;
        end
    end

endmodule

FILE: src/simplest_fraction_in_interval.sv
// Top level: sequencer, input checks and output register of the simplest-fraction block.
//
//  channel | direction | handshake                    | word
//  in      | input     | i_in_valid / o_in_ready      | i_in_word  (low, high, den)
//  out     | output    | o_out_valid / i_out_ready    | o_out_word (num, den, bad flag)
//
// On acceptance the bounds are loaded, then the mediant unit tests one Stern-Brocot
// mediant per cycle until one lies strictly inside the interval; that one goes to the
// output register. A bad interval skips the search. The input is not ready while a
// search runs. A finished answer waits for the output register to be free.
// Reset is synchronous and active low; it empties the block.
`timescale 1ns / 1ps

module simplest_fraction_in_interval #(
    parameter int DEN_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sfi_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sfi_pkg::t_out_word o_out_word
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_bad, n_bad;
    logic   r_out_valid, n_out_valid;
    sfi_pkg::t_out_word r_out, n_out;

    sfi_pkg::t_sfi_ctl   w_ctl;
    logic [DEN_BITS-1:0] w_lo, w_hi, w_dn;
    logic                w_in_bad, w_hit, w_accept, w_out_free, w_finish;
    logic [DEN_BITS+1:0] w_med_num, w_med_den;

    // Fields are taken modulo 2^DEN_BITS.
    assign w_lo = DEN_BITS'(i_in_word.low_num);
    assign w_hi = DEN_BITS'(i_in_word.high_num);
    assign w_dn = DEN_BITS'(i_in_word.common_den);

    assign w_in_bad   = (w_dn == '0) || (w_lo >= w_hi) || (w_lo >= w_dn);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == S_RUN) && (r_bad || w_hit) && w_out_free;

    sfi_bounds #(
        .DEN_BITS(DEN_BITS)
    ) u_bounds (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_lo      (w_lo),
        .i_hi      (w_hi),
        .i_dn      (w_dn),
        .o_hit     (w_hit),
        .o_med_num (w_med_num),
        .o_med_den (w_med_den)
    );

    always_comb begin
        n_state     = r_state;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_ctl.load  = 1'b0;
        w_ctl.step  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_bad      = w_in_bad;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (w_finish) begin
                    n_out_valid = 1'b1;
                    if (r_bad) begin
                        n_out.frac_num     = '0;
                        n_out.frac_den     = '0;
                        n_out.bad_interval = 1'b1;
                    end else begin
                        n_out.frac_num     = sfi_pkg::OUT_W'(w_med_num);
                        n_out.frac_den     = sfi_pkg::OUT_W'(w_med_den);
                        n_out.bad_interval = 1'b0;
                    end
                    n_state = S_IDLE;
                end else if (!r_bad && !w_hit) begin
                    w_ctl.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input still ready right after a word was taken");

    a_bad_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.bad_interval) |->
            (o_out_word.frac_num == '0 && o_out_word.frac_den == '0))
        else $error("bad interval result carries a nonzero fraction");

    a_no_step_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_bad) |-> !w_ctl.step)
        else $error("mediant step taken on a bad interval");

    a_taken_and_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !w_finish) |=> !o_out_valid)
        else $error("output word shown again after it was taken");
`endif

endmodule
